// ----- hw/rtl/q2e_pkg.sv -----
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, payload types, the CORDIC arctangent table and the helpers
// used by the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int COMPONENT_BITS    = 16;
  localparam int WORK_BITS         = 28;
  localparam int EXT_BITS          = (COMPONENT_BITS > WORK_BITS) ? COMPONENT_BITS : WORK_BITS;
  localparam int UP_SHIFT          = (COMPONENT_BITS < WORK_BITS) ? WORK_BITS - COMPONENT_BITS : 0;
  localparam int DOWN_SHIFT        = (COMPONENT_BITS > WORK_BITS) ? COMPONENT_BITS - WORK_BITS : 0;
  localparam int ANGLE_BITS        = 16;
  localparam int PROD_BITS         = 2 * WORK_BITS;
  localparam int ROT_BITS          = 32;
  localparam int RPROD_BITS        = 2 * ROT_BITS;
  localparam int VEC_BITS          = 62;
  localparam int NORM_EXP          = 30;
  localparam int CORDIC_BITS       = 34;
  localparam int PHASE_BITS        = 34;
  localparam int ROLL_BITS         = PHASE_BITS + 1;
  localparam int TABLE_LEN         = 30;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ROUND_SHIFT       = 17;

  localparam logic signed [PHASE_BITS-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ANGLE_BITS-1:0] PI_Q13 = 16'sd25736;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] heading_angle;
  } euler_t;

  function automatic logic signed [PHASE_BITS-1:0] atan_q30(input int idx);
    logic signed [PHASE_BITS-1:0] r;
    unique case (idx)
      0:  r = 34'sh3243F6A8;
      1:  r = 34'sh1DAC6705;
      2:  r = 34'sh0FADBAFC;
      3:  r = 34'sh07F56EA6;
      4:  r = 34'sh03FEAB76;
      5:  r = 34'sh01FFD55B;
      6:  r = 34'sh00FFFAAA;
      7:  r = 34'sh007FFF55;
      8:  r = 34'sh003FFFEA;
      9:  r = 34'sh001FFFFD;
      10: r = 34'sh000FFFFF;
      11: r = 34'sh0007FFFF;
      12: r = 34'sh0003FFFF;
      13: r = 34'sh0001FFFF;
      14: r = 34'sh0000FFFF;
      15: r = 34'sh00007FFF;
      16: r = 34'sh00003FFF;
      17: r = 34'sh00001FFF;
      18: r = 34'sh00000FFF;
      19: r = 34'sh000007FF;
      20: r = 34'sh000003FF;
      21: r = 34'sh000001FF;
      22: r = 34'sh000000FF;
      23: r = 34'sh0000007F;
      24: r = 34'sh0000003F;
      25: r = 34'sh0000001F;
      26: r = 34'sh0000000F;
      27: r = 34'sh00000008;
      28: r = 34'sh00000004;
      29: r = 34'sh00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [WORK_BITS-1:0] to_work(
    input logic signed [COMPONENT_BITS-1:0] v
  );
    logic signed [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    e = e <<< UP_SHIFT;
    e = e >>> DOWN_SHIFT;
    return WORK_BITS'(e);
  endfunction

  function automatic logic signed [ANGLE_BITS-1:0] round_q13(
    input logic signed [ROLL_BITS-1:0] a
  );
    logic signed [ROLL_BITS-1:0] s;
    logic signed [ROLL_BITS-1:0] r;
    logic signed [ANGLE_BITS-1:0] o;
    s = a + ROLL_BITS'(65536);
    r = s >>> ROUND_SHIFT;
    if (r > ROLL_BITS'(PI_Q13)) begin
      o = PI_Q13;
    end else if (r < -ROLL_BITS'(PI_Q13)) begin
      o = -PI_Q13;
    end else begin
      o = ANGLE_BITS'(r);
    end
    return o;
  endfunction

endpackage

// ----- hw/rtl/q2e_atan2.sv -----
// ----------------------------------------------------------------------------
// q2e_atan2
// Pipelined atan2: half-plane fold, six-step normalizing shift search, then
// one vectoring CORDIC iteration per stage. Carries a side tag along.
// ----------------------------------------------------------------------------
module q2e_atan2 #(
  parameter int STAGES   = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int TAG_BITS = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [q2e_pkg::VEC_BITS-1:0] y_i,
  input  logic signed [q2e_pkg::VEC_BITS-1:0] x_i,
  input  logic [TAG_BITS-1:0]                 tag_i,
  output logic                                valid_o,
  output logic signed [q2e_pkg::PHASE_BITS-1:0] angle_o,
  output logic [TAG_BITS-1:0]                 tag_o
);
  import q2e_pkg::*;

  localparam int WIDE  = VEC_BITS + NORM_EXP;
  localparam int STEPS = $clog2(VEC_BITS);
  localparam logic signed [WIDE-1:0] LIM     = WIDE'(1) <<< NORM_EXP;
  localparam logic signed [WIDE-1:0] NEG_LIM = -LIM;

  logic signed [VEC_BITS-1:0]   pre_x, pre_y;
  logic signed [PHASE_BITS-1:0] pre_off;

  logic signed [WIDE-1:0]       nx_q   [0:STEPS];
  logic signed [WIDE-1:0]       ny_q   [0:STEPS];
  logic signed [PHASE_BITS-1:0] noff_q [0:STEPS];
  logic                         nzero_q[0:STEPS];
  logic [TAG_BITS-1:0]          ntag_q [0:STEPS];
  logic                         nvld_q [0:STEPS];

  logic signed [CORDIC_BITS-1:0] cx_q   [0:STAGES-1];
  logic signed [CORDIC_BITS-1:0] cy_q   [0:STAGES-1];
  logic signed [PHASE_BITS-1:0]  cz_q   [0:STAGES-1];
  logic                          czero_q[0:STAGES-1];
  logic [TAG_BITS-1:0]           ctag_q [0:STAGES-1];
  logic                          cvld_q [0:STAGES-1];

  always_comb begin
    if (x_i < 0) begin
      pre_x   = -x_i;
      pre_y   = -y_i;
      pre_off = (y_i >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      pre_x   = x_i;
      pre_y   = y_i;
      pre_off = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q[0]    <= WIDE'(pre_x) <<< NORM_EXP;
      ny_q[0]    <= WIDE'(pre_y) <<< NORM_EXP;
      noff_q[0]  <= pre_off;
      nzero_q[0] <= (x_i == '0) && (y_i == '0);
      ntag_q[0]  <= tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvld_q[0] <= 1'b0;
    end else if (en_i) begin
      nvld_q[0] <= valid_i;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_norm
    localparam int SH = 1 << (STEPS - k);
    logic signed [WIDE-1:0] tx, ty;
    logic                   big;

    assign tx  = nx_q[k-1] >>> SH;
    assign ty  = ny_q[k-1] >>> SH;
    assign big = (tx >= LIM) || (tx <= NEG_LIM) || (ty >= LIM) || (ty <= NEG_LIM);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[k]    <= big ? tx : nx_q[k-1];
        ny_q[k]    <= big ? ty : ny_q[k-1];
        noff_q[k]  <= noff_q[k-1];
        nzero_q[k] <= nzero_q[k-1];
        ntag_q[k]  <= ntag_q[k-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nvld_q[k] <= 1'b0;
      end else if (en_i) begin
        nvld_q[k] <= nvld_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [CORDIC_BITS-1:0] xin, yin;
    logic signed [PHASE_BITS-1:0]  zin;
    logic                          zero_in, vld_in;
    logic [TAG_BITS-1:0]           tag_in;

    if (i == 0) begin : g_first
      assign xin     = CORDIC_BITS'(nx_q[STEPS] >>> 1);
      assign yin     = CORDIC_BITS'(ny_q[STEPS] >>> 1);
      assign zin     = noff_q[STEPS];
      assign zero_in = nzero_q[STEPS];
      assign tag_in  = ntag_q[STEPS];
      assign vld_in  = nvld_q[STEPS];
    end else begin : g_next
      assign xin     = cx_q[i-1];
      assign yin     = cy_q[i-1];
      assign zin     = cz_q[i-1];
      assign zero_in = czero_q[i-1];
      assign tag_in  = ctag_q[i-1];
      assign vld_in  = cvld_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yin > 0) begin
          cx_q[i] <= xin + (yin >>> i);
          cy_q[i] <= yin - (xin >>> i);
          cz_q[i] <= zin + atan_q30(i);
        end else begin
          cx_q[i] <= xin - (yin >>> i);
          cy_q[i] <= yin + (xin >>> i);
          cz_q[i] <= zin - atan_q30(i);
        end
        czero_q[i] <= zero_in;
        ctag_q[i]  <= tag_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cvld_q[i] <= 1'b0;
      end else if (en_i) begin
        cvld_q[i] <= vld_in;
      end
    end
  end

  assign valid_o = cvld_q[STAGES-1];
  assign angle_o = czero_q[STAGES-1] ? '0 : cz_q[STAGES-1];
  assign tag_o   = ctag_q[STAGES-1];

endmodule

// ----- hw/rtl/q2e_rotate.sv -----
// ----------------------------------------------------------------------------
// q2e_rotate
// Pipelined rotation CORDIC: turns two coordinate pairs by the same angle,
// one iteration per stage, with a side tag.
// ----------------------------------------------------------------------------
module q2e_rotate #(
  parameter int STAGES   = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int TAG_BITS = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [q2e_pkg::ROT_BITS-1:0]   a0_i,
  input  logic signed [q2e_pkg::ROT_BITS-1:0]   b0_i,
  input  logic signed [q2e_pkg::ROT_BITS-1:0]   a1_i,
  input  logic signed [q2e_pkg::ROT_BITS-1:0]   b1_i,
  input  logic signed [q2e_pkg::PHASE_BITS-1:0] theta_i,
  input  logic [TAG_BITS-1:0]                   tag_i,
  output logic                                  valid_o,
  output logic signed [q2e_pkg::ROT_BITS-1:0]   a0_o,
  output logic signed [q2e_pkg::ROT_BITS-1:0]   b0_o,
  output logic signed [q2e_pkg::ROT_BITS-1:0]   a1_o,
  output logic signed [q2e_pkg::ROT_BITS-1:0]   b1_o,
  output logic [TAG_BITS-1:0]                   tag_o
);
  import q2e_pkg::*;

  logic signed [ROT_BITS-1:0]   a0_q [0:STAGES-1];
  logic signed [ROT_BITS-1:0]   b0_q [0:STAGES-1];
  logic signed [ROT_BITS-1:0]   a1_q [0:STAGES-1];
  logic signed [ROT_BITS-1:0]   b1_q [0:STAGES-1];
  logic signed [PHASE_BITS-1:0] th_q [0:STAGES-1];
  logic [TAG_BITS-1:0]          tag_q[0:STAGES-1];
  logic                         vld_q[0:STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [ROT_BITS-1:0]   a0, b0, a1, b1;
    logic signed [PHASE_BITS-1:0] th;
    logic [TAG_BITS-1:0]          tg;
    logic                         vl;

    if (i == 0) begin : g_first
      assign a0 = a0_i;
      assign b0 = b0_i;
      assign a1 = a1_i;
      assign b1 = b1_i;
      assign th = theta_i;
      assign tg = tag_i;
      assign vl = valid_i;
    end else begin : g_next
      assign a0 = a0_q[i-1];
      assign b0 = b0_q[i-1];
      assign a1 = a1_q[i-1];
      assign b1 = b1_q[i-1];
      assign th = th_q[i-1];
      assign tg = tag_q[i-1];
      assign vl = vld_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (th >= 0) begin
          a0_q[i] <= a0 - (b0 >>> i);
          b0_q[i] <= b0 + (a0 >>> i);
          a1_q[i] <= a1 - (b1 >>> i);
          b1_q[i] <= b1 + (a1 >>> i);
          th_q[i] <= th - atan_q30(i);
        end else begin
          a0_q[i] <= a0 + (b0 >>> i);
          b0_q[i] <= b0 - (a0 >>> i);
          a1_q[i] <= a1 + (b1 >>> i);
          b1_q[i] <= b1 - (a1 >>> i);
          th_q[i] <= th + atan_q30(i);
        end
        tag_q[i] <= tg;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vl;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign a0_o    = a0_q[STAGES-1];
  assign b0_o    = b0_q[STAGES-1];
  assign a1_o    = a1_q[STAGES-1];
  assign b1_o    = b1_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];

endmodule

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Attitude quaternion (Q1.14) to heading, pitch and roll (Q3.13 radians)
// through three pipelined atan2 units and two rotation CORDIC units.
// ----------------------------------------------------------------------------
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o    in_quat_i   (quat_t)
//   out      out  out_valid_o / out_stall_i  out_euler_o (euler_t)
//
// One quaternion enters per cycle while in_stall_o is low; the path runs
// through a chain of five CORDIC units, one iteration per stage.
// in_stall_o is a register: it rises when the output skid stage fills and
// the whole pipeline then holds until out_stall_i drops.
// Reset clears every valid bit; no state carries between items.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  q2e_pkg::quat_t  in_quat_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output q2e_pkg::euler_t out_euler_o
);
  import q2e_pkg::*;

  localparam int TAG_A  = 4 * WORK_BITS;
  localparam int TAG_B  = 4 * ROT_BITS + PHASE_BITS;
  localparam int TAG_C  = 2 * PHASE_BITS;
  localparam logic signed [ROLL_BITS-1:0] PI_R     = ROLL_BITS'(PI_Q30);
  localparam logic signed [ROLL_BITS-1:0] TWO_PI_R = PI_R <<< 1;

  logic pipe_en;
  logic out_free, s9_fire;

  logic                        s0_valid_q;
  logic signed [WORK_BITS-1:0] s0_w_q, s0_x_q, s0_y_q, s0_z_q;

  logic                        s1_valid_q;
  logic signed [PROD_BITS-1:0] s1_ww_q, s1_xx_q, s1_yy_q, s1_zz_q, s1_xy_q, s1_wz_q;
  logic signed [WORK_BITS-1:0] s1_w_q, s1_x_q, s1_y_q, s1_z_q;

  logic                        s2_valid_q;
  logic signed [VEC_BITS-1:0]  s2_hy_q, s2_hx_q;
  logic [TAG_A-1:0]            s2_tag_q;

  logic                         h_valid;
  logic signed [PHASE_BITS-1:0] h_angle;
  logic [TAG_A-1:0]             h_tag;
  logic signed [WORK_BITS-1:0]  h_w, h_x, h_y, h_z;

  logic                         s3_valid_q;
  logic signed [ROT_BITS-1:0]   s3_w_q, s3_x_q, s3_y_q, s3_z_q;
  logic signed [PHASE_BITS-1:0] s3_th_q, s3_hq_q;

  logic                         ra_valid;
  logic signed [ROT_BITS-1:0]   ra_pw, ra_pz, ra_px, ra_py;
  logic signed [PHASE_BITS-1:0] ra_hq;

  logic                          s4_valid_q;
  logic signed [RPROD_BITS-1:0]  s4_wy_q, s4_xz_q, s4_ww_q, s4_xx_q, s4_yy_q, s4_zz_q;
  logic signed [ROT_BITS-1:0]    s4_pw_q, s4_px_q, s4_py_q, s4_pz_q;
  logic signed [PHASE_BITS-1:0]  s4_hq_q;

  logic                        s5_valid_q;
  logic signed [VEC_BITS-1:0]  s5_vy_q, s5_vx_q;
  logic [TAG_B-1:0]            s5_tag_q;

  logic                         p_valid;
  logic signed [PHASE_BITS-1:0] p_angle;
  logic [TAG_B-1:0]             p_tag;
  logic signed [ROT_BITS-1:0]   p_pw, p_px, p_py, p_pz;
  logic signed [PHASE_BITS-1:0] p_hq;

  logic                         s6_valid_q;
  logic signed [ROT_BITS-1:0]   s6_pw_q, s6_px_q, s6_py_q, s6_pz_q;
  logic signed [PHASE_BITS-1:0] s6_th_q, s6_hq_q, s6_pq_q;

  logic                         rb_valid;
  logic signed [ROT_BITS-1:0]   rb_rw, rb_rx;
  logic [TAG_C-1:0]             rb_tag;

  logic                        s7_valid_q;
  logic signed [VEC_BITS-1:0]  s7_rx_q, s7_rw_q;
  logic [TAG_C-1:0]            s7_tag_q;

  logic                         r_valid;
  logic signed [PHASE_BITS-1:0] r_angle;
  logic [TAG_C-1:0]             r_tag;
  logic signed [PHASE_BITS-1:0] r_hq, r_pq;
  logic signed [ROLL_BITS-1:0]  roll_dbl, roll_d;

  logic                         s8_valid_q;
  logic signed [ROLL_BITS-1:0]  s8_rq_q;
  logic signed [PHASE_BITS-1:0] s8_hq_q, s8_pq_q;

  logic   s9_valid_q;
  euler_t s9_q;

  logic   out_valid_q, skid_valid_q;
  euler_t out_q, skid_q;

  assign pipe_en    = ~skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // stage 0: scale components to working width
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_w_q <= to_work(in_quat_i.quat_w);
      s0_x_q <= to_work(in_quat_i.quat_x);
      s0_y_q <= to_work(in_quat_i.quat_y);
      s0_z_q <= to_work(in_quat_i.quat_z);
    end
  end

  // stage 1: heading products
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_ww_q <= PROD_BITS'(s0_w_q) * PROD_BITS'(s0_w_q);
      s1_xx_q <= PROD_BITS'(s0_x_q) * PROD_BITS'(s0_x_q);
      s1_yy_q <= PROD_BITS'(s0_y_q) * PROD_BITS'(s0_y_q);
      s1_zz_q <= PROD_BITS'(s0_z_q) * PROD_BITS'(s0_z_q);
      s1_xy_q <= PROD_BITS'(s0_x_q) * PROD_BITS'(s0_y_q);
      s1_wz_q <= PROD_BITS'(s0_w_q) * PROD_BITS'(s0_z_q);
      s1_w_q  <= s0_w_q;
      s1_x_q  <= s0_x_q;
      s1_y_q  <= s0_y_q;
      s1_z_q  <= s0_z_q;
    end
  end

  // stage 2: heading atan2 operands
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_hy_q  <= (VEC_BITS'(s1_xy_q) + VEC_BITS'(s1_wz_q)) <<< 1;
      s2_hx_q  <= VEC_BITS'(s1_ww_q) + VEC_BITS'(s1_xx_q)
                - VEC_BITS'(s1_yy_q) - VEC_BITS'(s1_zz_q);
      s2_tag_q <= {s1_w_q, s1_x_q, s1_y_q, s1_z_q};
    end
  end

  q2e_atan2 #(
    .STAGES   (CORDIC_STAGES),
    .TAG_BITS (TAG_A)
  ) u_heading (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s2_valid_q),
    .y_i     (s2_hy_q),
    .x_i     (s2_hx_q),
    .tag_i   (s2_tag_q),
    .valid_o (h_valid),
    .angle_o (h_angle),
    .tag_o   (h_tag)
  );

  assign {h_w, h_x, h_y, h_z} = h_tag;

  // stage 3: minus half heading
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_w_q  <= ROT_BITS'(h_w);
      s3_x_q  <= ROT_BITS'(h_x);
      s3_y_q  <= ROT_BITS'(h_y);
      s3_z_q  <= ROT_BITS'(h_z);
      s3_th_q <= (-h_angle) >>> 1;
      s3_hq_q <= h_angle;
    end
  end

  q2e_rotate #(
    .STAGES   (CORDIC_STAGES),
    .TAG_BITS (PHASE_BITS)
  ) u_unheading (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s3_valid_q),
    .a0_i    (s3_w_q),
    .b0_i    (s3_z_q),
    .a1_i    (s3_x_q),
    .b1_i    (s3_y_q),
    .theta_i (s3_th_q),
    .tag_i   (s3_hq_q),
    .valid_o (ra_valid),
    .a0_o    (ra_pw),
    .b0_o    (ra_pz),
    .a1_o    (ra_px),
    .b1_o    (ra_py),
    .tag_o   (ra_hq)
  );

  // stage 4: pitch products
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_wy_q <= RPROD_BITS'(ra_pw) * RPROD_BITS'(ra_py);
      s4_xz_q <= RPROD_BITS'(ra_px) * RPROD_BITS'(ra_pz);
      s4_ww_q <= RPROD_BITS'(ra_pw) * RPROD_BITS'(ra_pw);
      s4_xx_q <= RPROD_BITS'(ra_px) * RPROD_BITS'(ra_px);
      s4_yy_q <= RPROD_BITS'(ra_py) * RPROD_BITS'(ra_py);
      s4_zz_q <= RPROD_BITS'(ra_pz) * RPROD_BITS'(ra_pz);
      s4_pw_q <= ra_pw;
      s4_px_q <= ra_px;
      s4_py_q <= ra_py;
      s4_pz_q <= ra_pz;
      s4_hq_q <= ra_hq;
    end
  end

  // stage 5: pitch atan2 operands
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s5_vy_q  <= (VEC_BITS'(s4_wy_q) - VEC_BITS'(s4_xz_q)) <<< 1;
      s5_vx_q  <= VEC_BITS'(s4_ww_q) + VEC_BITS'(s4_xx_q)
                - VEC_BITS'(s4_yy_q) - VEC_BITS'(s4_zz_q);
      s5_tag_q <= {s4_pw_q, s4_px_q, s4_py_q, s4_pz_q, s4_hq_q};
    end
  end

  q2e_atan2 #(
    .STAGES   (CORDIC_STAGES),
    .TAG_BITS (TAG_B)
  ) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s5_valid_q),
    .y_i     (s5_vy_q),
    .x_i     (s5_vx_q),
    .tag_i   (s5_tag_q),
    .valid_o (p_valid),
    .angle_o (p_angle),
    .tag_o   (p_tag)
  );

  assign {p_pw, p_px, p_py, p_pz, p_hq} = p_tag;

  // stage 6: minus half pitch
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s6_pw_q <= p_pw;
      s6_px_q <= p_px;
      s6_py_q <= p_py;
      s6_pz_q <= p_pz;
      s6_th_q <= (-p_angle) >>> 1;
      s6_hq_q <= p_hq;
      s6_pq_q <= p_angle;
    end
  end

  q2e_rotate #(
    .STAGES   (CORDIC_STAGES),
    .TAG_BITS (TAG_C)
  ) u_unpitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s6_valid_q),
    .a0_i    (s6_pw_q),
    .b0_i    (s6_py_q),
    .a1_i    (s6_pz_q),
    .b1_i    (s6_px_q),
    .theta_i (s6_th_q),
    .tag_i   ({s6_hq_q, s6_pq_q}),
    .valid_o (rb_valid),
    .a0_o    (rb_rw),
    .b0_o    (),
    .a1_o    (),
    .b1_o    (rb_rx),
    .tag_o   (rb_tag)
  );

  // stage 7: roll atan2 operands
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s7_rx_q  <= VEC_BITS'(rb_rx);
      s7_rw_q  <= VEC_BITS'(rb_rw);
      s7_tag_q <= rb_tag;
    end
  end

  q2e_atan2 #(
    .STAGES   (CORDIC_STAGES),
    .TAG_BITS (TAG_C)
  ) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s7_valid_q),
    .y_i     (s7_rx_q),
    .x_i     (s7_rw_q),
    .tag_i   (s7_tag_q),
    .valid_o (r_valid),
    .angle_o (r_angle),
    .tag_o   (r_tag)
  );

  assign {r_hq, r_pq} = r_tag;

  // stage 8: double roll and wrap into +-pi
  always_comb begin
    roll_dbl = ROLL_BITS'(r_angle) <<< 1;
    if (roll_dbl < -PI_R) begin
      roll_d = roll_dbl + TWO_PI_R;
    end else if (roll_dbl > PI_R) begin
      roll_d = roll_dbl - TWO_PI_R;
    end else begin
      roll_d = roll_dbl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s8_rq_q <= roll_d;
      s8_hq_q <= r_hq;
      s8_pq_q <= r_pq;
    end
  end

  // stage 9: round to Q3.13 and saturate
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s9_q.pitch_angle   <= round_q13(ROLL_BITS'(s8_pq_q));
      s9_q.roll_angle    <= round_q13(s8_rq_q);
      s9_q.heading_angle <= round_q13(ROLL_BITS'(s8_hq_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
      s9_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_q <= in_valid_i;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= h_valid;
      s4_valid_q <= ra_valid;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= p_valid;
      s7_valid_q <= rb_valid;
      s8_valid_q <= r_valid;
      s9_valid_q <= s8_valid_q;
    end
  end

  // output register with skid stage
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign s9_fire  = s9_valid_q & pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | s9_fire;
      skid_valid_q <= 1'b0;
    end else if (s9_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : s9_q;
    end
    if (!out_free && s9_fire) begin
      skid_q <= s9_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_euler_o = out_q;

endmodule
